[src/assert_macros.svh]
// Concurrent assertion helpers; they expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SRL_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define SRL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/srl_pkg.sv]
package srl_pkg;

	localparam int CoordBits = 5;
	// Cross products reach about (2^CoordBits)^2; keep a sign and a carry bit.
	localparam int ProdBits  = 2 * CoordBits + 2;

	typedef logic [CoordBits-1:0] coord_t;
	typedef logic signed [ProdBits-1:0] prod_t;
	typedef logic [1:0] quad_t;
	typedef logic [31:0] color_t;

	// Quadrant code: bit 1 set when x runs down, bit 0 set when y runs down.
	localparam quad_t QUAD_XUP_YUP = 2'd0;
	localparam quad_t QUAD_XUP_YDN = 2'd1;
	localparam quad_t QUAD_XDN_YUP = 2'd2;
	localparam quad_t QUAD_XDN_YDN = 2'd3;

	function automatic color_t quad_color(input quad_t quad);
		color_t c;
		unique case (quad)
			QUAD_XUP_YUP: c = 32'hEEEEEEFF;
			QUAD_XUP_YDN: c = 32'h99EEEEFF;
			QUAD_XDN_YUP: c = 32'hEE99EEFF;
			QUAD_XDN_YDN: c = 32'hEEEE99FF;
			default:      c = 32'hEEEEEEFF;
		endcase
		return c;
	endfunction

endpackage

[src/srl_if.sv]
interface srl_line_if;
	logic                   valid;
	logic                   ready;
	srl_pkg::coord_t        x_start;
	srl_pkg::coord_t        y_start;
	srl_pkg::coord_t        x_end;
	srl_pkg::coord_t        y_end;

	modport source (output valid, output x_start, output y_start, output x_end,
		output y_end, input ready);
	modport sink (input valid, input x_start, input y_start, input x_end,
		input y_end, output ready);
endinterface

interface srl_pixel_if;
	logic                   valid;
	logic                   ready;
	srl_pkg::coord_t        pixel_x;
	srl_pkg::coord_t        pixel_y;
	srl_pkg::color_t        pixel_color;
	logic                   last_pixel;

	modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
		output last_pixel, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input pixel_color,
		input last_pixel, output ready);
endinterface

[src/stairstep_line_rasterizer_unit.sv]
// Channel    Dir  Payload                               Request moves
// line_in    in   x_start, y_start, x_end, y_end        one line segment
// pixel_out  out  pixel_x, pixel_y, pixel_color, last   one pixel of the staircase
//
// A line of |dx|+|dy|+1 pixels or fewer emits one pixel per cycle while pixel_out
// is not stalled; the single step unit (one add and two compares on the running
// cross products) sets that. A new line is taken once the last pixel of the
// previous one is in the output register.
// Reset clears the walk and output valid; pixel_out stalls freeze the walk.
`include "assert_macros.svh"

module stairstep_line_rasterizer_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	srl_line_if.sink              line_in,
	srl_pixel_if.source           pixel_out
);

	logic                  busy_q;
	srl_pkg::coord_t       x_q, y_q, x1_q, y1_q;
	srl_pkg::quad_t        quad_q;
	srl_pkg::prod_t        dx_q, dy_q, p_q, q_q;
	logic                  ov_q;
	srl_pkg::coord_t       px_q, py_q;
	srl_pkg::color_t       col_q;
	logic                  last_q;

	srl_pkg::prod_t        dx_in, dy_in, step_sum;
	srl_pkg::quad_t        quad_in;
	logic                  adv, step_ge, step_x, step_last, dx_zero;

	assign line_in.ready = !busy_q;
	assign adv = busy_q && (!ov_q || pixel_out.ready);

	assign dx_in = srl_pkg::prod_t'($signed({1'b0, line_in.x_end}))
		- srl_pkg::prod_t'($signed({1'b0, line_in.x_start}));
	assign dy_in = srl_pkg::prod_t'($signed({1'b0, line_in.y_end}))
		- srl_pkg::prod_t'($signed({1'b0, line_in.y_start}));
	assign quad_in = {line_in.x_end < line_in.x_start, line_in.y_end < line_in.y_start};

	// Shared step unit: Q +/- dx against P = dy*(x-x0), Q = (y-y0)*dx.
	assign dx_zero  = (dx_q == '0);
	assign step_sum = quad_q[1] ? (q_q - dx_q) : (q_q + dx_q);
	assign step_ge  = (quad_q == srl_pkg::QUAD_XUP_YDN) ? (step_sum > p_q)
		: (step_sum >= p_q);
	assign step_x   = !dx_zero && (q_q <= p_q) && step_ge;
	// Current pixel is inside, so only a step off the end row/column ends the line.
	assign step_last = step_x ? (x_q == x1_q) : (y_q == y1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (line_in.valid && !busy_q) begin
			busy_q <= 1'b1;
		end else if (adv && step_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_in.valid && !busy_q) begin
			x_q    <= line_in.x_start;
			y_q    <= line_in.y_start;
			x1_q   <= line_in.x_end;
			y1_q   <= line_in.y_end;
			dx_q   <= dx_in;
			dy_q   <= dy_in;
			quad_q <= quad_in;
			p_q    <= '0;
			q_q    <= '0;
		end else if (adv) begin
			if (step_x) begin
				x_q <= quad_q[1] ? (x_q - srl_pkg::coord_t'(1)) : (x_q + srl_pkg::coord_t'(1));
				p_q <= quad_q[1] ? (p_q - dy_q) : (p_q + dy_q);
			end else begin
				y_q <= quad_q[0] ? (y_q - srl_pkg::coord_t'(1)) : (y_q + srl_pkg::coord_t'(1));
				q_q <= quad_q[0] ? (q_q - dx_q) : (q_q + dx_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= 1'b1;
		end else if (pixel_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q   <= x_q;
			py_q   <= y_q;
			col_q  <= srl_pkg::quad_color(quad_q);
			last_q <= step_last;
		end
	end

	assign pixel_out.valid       = ov_q;
	assign pixel_out.pixel_x     = px_q;
	assign pixel_out.pixel_y     = py_q;
	assign pixel_out.pixel_color = col_q;
	assign pixel_out.last_pixel  = last_q;

	`SRL_ASSERT_NEXT(a_last_ends_walk, adv && step_last, !busy_q)
	`SRL_ASSERT_NEXT(a_vertical_holds_x, adv && dx_zero, x_q == $past(x_q))
	`SRL_ASSERT_NEXT(a_step_fills_output, adv, pixel_out.valid)

endmodule
